[rtl/plir_pkg.sv]
package plir_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned SegBits   = 25;
  localparam int unsigned TotBits   = 40;
  localparam int unsigned CfgIdxBits = 2;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_AX = 2'd0,
    CFG_AY = 2'd1,
    CFG_BX = 2'd2,
    CFG_BY = 2'd3
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CMP,
    ST_DIV_START,
    ST_DIV,
    ST_SQ_START,
    ST_SQ,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

[rtl/plir_if.sv]
interface plir_vtx_if (input logic clk_i);
  logic                       valid;
  logic                       ready;
  plir_pkg::coord_t           vertex_x;
  plir_pkg::coord_t           vertex_y;
  logic                       start_new;
  modport source (output valid, vertex_x, vertex_y, start_new, input ready);
  modport sink   (input valid, vertex_x, vertex_y, start_new, output ready);
endinterface

interface plir_res_if (input logic clk_i);
  logic                         valid;
  logic                         ready;
  logic [plir_pkg::SegBits-1:0] segment_inside;
  logic [plir_pkg::TotBits-1:0] total_inside;
  modport source (output valid, segment_inside, total_inside, input ready);
  modport sink   (input valid, segment_inside, total_inside, output ready);
endinterface

[rtl/plir_div.sv]
// Restoring divider: quotient of (num << 28) / den, one bit per cycle.
module plir_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] num_i,
  input  logic [33:0] den_i,
  output logic        busy_o,
  output logic [28:0] quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [62:0] dvd_q, dvd_d;
  logic [34:0] rem_q, rem_d;
  logic [33:0] den_q, den_d;
  logic [28:0] quo_q, quo_d;
  logic [35:0] trial;

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quo_q;

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    trial = {rem_q, dvd_q[62]} - {2'b00, den_q};
    if (start_i) begin
      cnt_d = 6'd63;
      dvd_d = {1'b0, num_i, 28'd0};
      rem_d = '0;
      den_d = den_i;
      quo_d = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - 6'd1;
      dvd_d = {dvd_q[61:0], 1'b0};
      if (!trial[35]) begin
        rem_d = trial[34:0];
        quo_d = {quo_q[27:0], 1'b1};
      end else begin
        rem_d = {rem_q[33:0], dvd_q[62]};
        quo_d = {quo_q[27:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end
endmodule

[rtl/plir_sqrt.sv]
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
module plir_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q, bit_d;
  logic [63:0] sum;

  assign busy_o = (cnt_q != 6'd0);
  assign root_o = r_q[31:0];
  assign sum    = r_q + bit_q;

  always_comb begin
    cnt_d = cnt_q;
    v_d   = v_q;
    r_d   = r_q;
    bit_d = bit_q;
    if (start_i) begin
      cnt_d = 6'd32;
      v_d   = val_i;
      r_d   = '0;
      bit_d = 64'd1 << 62;
    end else if (busy_o) begin
      cnt_d = cnt_q - 6'd1;
      bit_d = bit_q >> 2;
      if (v_q >= sum) begin
        v_d = v_q - sum;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end
endmodule

[rtl/polyline_length_in_rectangle_core.sv]
// Sequence of a clipped segment from acceptance to result: setup, three clip
// steps, divider, square root, multiply, done. A zero-length segment or one
// parallel to an axis outside its slab leaves the clip steps early for done; a
// start or first-vertex transaction goes straight to done. One transaction at
// a time: the next vertex is accepted only after the result has been taken.
// Reset (rst_ni, asynchronous, active low) clears corners, vertex, flags, total.
module polyline_length_in_rectangle_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [plir_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [plir_pkg::CoordBits-1:0]    cfg_data_i,
  plir_vtx_if.sink                          vtx,
  plir_res_if.source                        res
);
  plir_pkg::state_e state_q, state_d;

  plir_pkg::coord_t ax_q, ay_q, bx_q, by_q;
  plir_pkg::coord_t px_q, py_q, vx_q, vy_q;
  logic             have_q, start_q;
  logic [39:0]      total_q;
  logic [24:0]      seg_q;
  logic             out_v_q;

  // Clip working registers. Each parameter is a fraction n/d, d > 0.
  logic signed [17:0] dx_q, dy_q;
  logic signed [17:0] t0n_q, t0d_q, t1n_q, t1d_q;
  logic signed [17:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic               out_q;
  logic [1:0]         step_q;
  logic [33:0]        num_q, den_q;
  logic [28:0]        fq_q;
  logic [24:0]        prod_q;

  logic        div_start, div_busy, sq_start, sq_busy;
  logic [28:0] quot;
  logic [31:0] root;
  logic [63:0] sq_val;

  assign vtx.ready = (state_q == plir_pkg::ST_IDLE) && !out_v_q;
  assign res.valid = out_v_q;
  assign res.segment_inside = seg_q;
  assign res.total_inside   = total_q;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
    end else if (cfg_we_i) begin
      unique case (plir_pkg::cfg_idx_e'(cfg_idx_i))
        plir_pkg::CFG_AX: ax_q <= cfg_data_i;
        plir_pkg::CFG_AY: ay_q <= cfg_data_i;
        plir_pkg::CFG_BX: bx_q <= cfg_data_i;
        plir_pkg::CFG_BY: by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One axis of the clip is applied per step: step 0 is x, step 1 is y,
  // step 2 checks t0 < t1. Enter and leave candidates come from the axis.
  logic signed [17:0] p0, dp, lo, hi, en_n, lv_n, ad;
  logic signed [35:0] c1l, c1r, c2l, c2r, c3l, c3r, dd;
  always_comb begin
    p0 = (step_q == 2'd0) ? 18'(px_q) : 18'(py_q);
    dp = (step_q == 2'd0) ? dx_q : dy_q;
    lo = (step_q == 2'd0) ? xlo_q : ylo_q;
    hi = (step_q == 2'd0) ? xhi_q : yhi_q;
    ad = dp[17] ? -dp : dp;
    en_n = dp[17] ? (p0 - hi) : (lo - p0);
    lv_n = dp[17] ? (p0 - lo) : (hi - p0);
    c1l = t0n_q * ad;   c1r = en_n * t0d_q;
    c2l = lv_n * t1d_q; c2r = t1n_q * ad;
    c3l = t0n_q * t1d_q; c3r = t1n_q * t0d_q;
    dd  = t0d_q * t1d_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plir_pkg::ST_IDLE:
        if (vtx.valid && vtx.ready) begin
          state_d = (vtx.start_new || !have_q) ? plir_pkg::ST_DONE : plir_pkg::ST_SETUP;
        end
      plir_pkg::ST_SETUP: state_d = plir_pkg::ST_CMP;
      plir_pkg::ST_CMP:
        if (out_q) state_d = plir_pkg::ST_DONE;
        else if (step_q == 2'd2) state_d = plir_pkg::ST_DIV_START;
      plir_pkg::ST_DIV_START: state_d = plir_pkg::ST_DIV;
      plir_pkg::ST_DIV: if (!div_busy) state_d = plir_pkg::ST_SQ_START;
      plir_pkg::ST_SQ_START: state_d = plir_pkg::ST_SQ;
      plir_pkg::ST_SQ: if (!sq_busy) state_d = plir_pkg::ST_MUL;
      plir_pkg::ST_MUL: state_d = plir_pkg::ST_DONE;
      plir_pkg::ST_DONE: state_d = plir_pkg::ST_IDLE;
      default: state_d = plir_pkg::ST_IDLE;
    endcase
  end

  // Unit start strobes.
  always_comb begin
    div_start = (state_q == plir_pkg::ST_DIV_START);
    sq_start  = (state_q == plir_pkg::ST_SQ_START);
  end

  logic signed [35:0] sdx2, sdy2;
  assign sdx2 = dx_q * dx_q;
  assign sdy2 = dy_q * dy_q;
  assign sq_val = {{1'b0, sdx2[32:0]} + {1'b0, sdy2[32:0]}, 30'd0};

  plir_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_q), .den_i(den_q),
    .busy_o(div_busy), .quot_o(quot)
  );

  plir_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val),
    .busy_o(sq_busy), .root_o(root)
  );

  // The length of this transaction: zero for a start, a first vertex or a
  // segment that misses the rectangle.
  logic [24:0] seg_new;
  assign seg_new = (!start_q && have_q && !out_q) ? prod_q : '0;

  logic [40:0] tot_sum;
  assign tot_sum = {1'b0, total_q} + {16'd0, seg_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plir_pkg::ST_IDLE;
      have_q  <= 1'b0;
      px_q    <= '0;
      py_q    <= '0;
      total_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res.valid && res.ready) out_v_q <= 1'b0;
      if (state_q == plir_pkg::ST_DONE) begin
        out_v_q <= 1'b1;
        px_q <= vx_q;
        py_q <= vy_q;
        have_q <= 1'b1;
        if (start_q) total_q <= '0;
        else if (have_q) total_q <= tot_sum[40] ? '1 : tot_sum[39:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      plir_pkg::ST_IDLE: begin
        vx_q <= vtx.vertex_x;
        vy_q <= vtx.vertex_y;
        start_q <= vtx.start_new;
        dx_q <= 18'(vtx.vertex_x) - 18'(px_q);
        dy_q <= 18'(vtx.vertex_y) - 18'(py_q);
      end
      plir_pkg::ST_SETUP: begin
        xlo_q <= (ax_q < bx_q) ? 18'(ax_q) : 18'(bx_q);
        xhi_q <= (ax_q < bx_q) ? 18'(bx_q) : 18'(ax_q);
        ylo_q <= (ay_q < by_q) ? 18'(ay_q) : 18'(by_q);
        yhi_q <= (ay_q < by_q) ? 18'(by_q) : 18'(ay_q);
        t0n_q <= 18'sd0; t0d_q <= 18'sd1;
        t1n_q <= 18'sd1; t1d_q <= 18'sd1;
        out_q <= (dx_q == 18'sd0) && (dy_q == 18'sd0);
        step_q <= 2'd0;
      end
      plir_pkg::ST_CMP: begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          if (!(c3l < c3r)) out_q <= 1'b1;
          num_q <= 34'(c3r - c3l);
          den_q <= 34'(dd);
        end else if (dp == 18'sd0) begin
          if (p0 < lo || p0 > hi) out_q <= 1'b1;
        end else begin
          if (c1l < c1r) begin t0n_q <= en_n; t0d_q <= ad; end
          if (c2l < c2r) begin t1n_q <= lv_n; t1d_q <= ad; end
        end
      end
      plir_pkg::ST_SQ: fq_q <= quot;
      plir_pkg::ST_MUL:
        prod_q <= 25'(({32'd0, root} * {35'd0, fq_q}) >> (43 - plir_pkg::FracBits));
      plir_pkg::ST_DONE: seg_q <= seg_new;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != plir_pkg::ST_IDLE) |-> !vtx.ready) else $error("ready while busy");
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_busy && sq_busy)) else $error("units overlap");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plir_pkg::ST_DONE) |=> res.valid) else $error("result lost");
`endif
endmodule
